// ----- rtl/ipv4_lpm_pkg.sv -----
// shared types, widths and codes of the ipv4 longest prefix forwarding block
package ipv4_lpm_pkg;

   // table depth default and the slots that the entry index can reach
   localparam int DEFAULT_TABLE_DEPTH = 16;
   localparam int INDEX_W             = 4;
   localparam int ENTRY_SLOTS         = 2 ** INDEX_W;

   // field widths
   localparam int ADDR_W    = 32;
   localparam int TTL_W     = 8;
   localparam int VERDICT_W = 3;

   // request beat layout, lowest bit first
   localparam int REQ_INDEX_LSB = 0;
   localparam int REQ_EVALID_LSB = REQ_INDEX_LSB + INDEX_W;
   localparam int REQ_RDEST_LSB = REQ_EVALID_LSB + 1;
   localparam int REQ_RMASK_LSB = REQ_RDEST_LSB + ADDR_W;
   localparam int REQ_RHOP_LSB  = REQ_RMASK_LSB + ADDR_W;
   localparam int REQ_SRC_LSB   = REQ_RHOP_LSB + ADDR_W;
   localparam int REQ_DST_LSB   = REQ_SRC_LSB + ADDR_W;
   localparam int REQ_TTL_LSB   = REQ_DST_LSB + ADDR_W;
   localparam int REQ_USED_W    = REQ_TTL_LSB + TTL_W;
   localparam int REQ_TDATA_W   = ((REQ_USED_W + 7) / 8) * 8;
   localparam int REQ_TUSER_W   = 1;

   // response beat layout, lowest bit first
   localparam int RSP_TDATA_W = ADDR_W + TTL_W;
   localparam int RSP_TUSER_W = VERDICT_W;

   // request kinds
   typedef enum logic [REQ_TUSER_W-1:0] {
      REQ_KIND_WRITE   = 1'b0,
      REQ_KIND_FORWARD = 1'b1
   } req_kind_type;

   // result verdicts
   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_FORWARD  = 3'd0,
      VERDICT_LOOPBACK = 3'd1,
      VERDICT_TTL_ZERO = 3'd2,
      VERDICT_NO_ROUTE = 3'd3,
      VERDICT_WRITE    = 3'd4
   } verdict_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic write_en;
      logic scan_start;
      logic scan_step;
      logic load_rsp;
   } dp_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic is_write;
      logic early_drop;
      logic last_entry;
   } dp_status_type;

endpackage

// ----- rtl/ipv4_lpm_ctrl.sv -----
// controller state machine: sequences capture, write, table scan and result hand-off
module ipv4_lpm_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   input  ipv4_lpm_pkg::dp_status_type status,
   output ipv4_lpm_pkg::dp_cmd_type   cmd
);
   import ipv4_lpm_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_EXEC   = 4'b0010,
      S_SCAN   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // output register can take a result when empty or draining this cycle
   assign out_free = !rsp_valid_ff || rsp_tready;

   // commands
   always_comb begin
      cmd            = '0;
      cmd.capture    = (state_ff == S_IDLE) && req_tvalid;
      cmd.write_en   = (state_ff == S_EXEC) && status.is_write;
      cmd.scan_start = (state_ff == S_EXEC) && !status.is_write && !status.early_drop;
      cmd.scan_step  = (state_ff == S_SCAN);
      cmd.load_rsp   = (state_ff == S_FINISH) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = cmd.scan_start ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            if (status.last_entry) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response valid flag
   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/ipv4_lpm_dpath.sv -----
// datapath: request registers, route table, scan compare and result register
module ipv4_lpm_dpath #(
   parameter int TABLE_DEPTH = ipv4_lpm_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [ipv4_lpm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic [ipv4_lpm_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input  ipv4_lpm_pkg::dp_cmd_type              cmd,
   output ipv4_lpm_pkg::dp_status_type           status,
   output logic [ipv4_lpm_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic [ipv4_lpm_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import ipv4_lpm_pkg::*;

   // only slots the entry index can reach are stored, the rest stay invalid
   localparam int STORE_DEPTH = (TABLE_DEPTH < ENTRY_SLOTS) ? TABLE_DEPTH : ENTRY_SLOTS;
   localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // captured request
   logic [REQ_TUSER_W-1:0] kind_ff;
   logic [INDEX_W-1:0]     index_ff;
   logic                   evalid_ff;
   logic [ADDR_W-1:0]      rdest_ff, rmask_ff, rhop_ff, src_ff, dst_ff;
   logic [TTL_W-1:0]       ttl_ff;

   // route table
   logic [ADDR_W-1:0] dest_tab_ff [STORE_DEPTH];
   logic [ADDR_W-1:0] mask_tab_ff [STORE_DEPTH];
   logic [ADDR_W-1:0] hop_tab_ff  [STORE_DEPTH];
   logic [STORE_DEPTH-1:0] valid_tab_ff, valid_tab_in;

   // scan state
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              found_ff, found_in;
   logic [ADDR_W-1:0] best_mask_ff, best_mask_in, best_hop_ff, best_hop_in;

   // result register
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0] rsp_user_ff, rsp_user_in;

   logic              slot_ok;
   logic [IDX_W-1:0]  wr_addr;
   logic [ADDR_W-1:0] cur_dest, cur_mask, cur_hop;
   logic              hit, take;
   logic              is_write, loopback, ttl_zero;
   verdict_type       verdict;
   logic [ADDR_W-1:0] hop_out;
   logic [TTL_W-1:0]  ttl_out;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_tuser;
         index_ff  <= req_tdata[REQ_INDEX_LSB +: INDEX_W];
         evalid_ff <= req_tdata[REQ_EVALID_LSB];
         rdest_ff  <= req_tdata[REQ_RDEST_LSB +: ADDR_W];
         rmask_ff  <= req_tdata[REQ_RMASK_LSB +: ADDR_W];
         rhop_ff   <= req_tdata[REQ_RHOP_LSB +: ADDR_W];
         src_ff    <= req_tdata[REQ_SRC_LSB +: ADDR_W];
         dst_ff    <= req_tdata[REQ_DST_LSB +: ADDR_W];
         ttl_ff    <= req_tdata[REQ_TTL_LSB +: TTL_W];
      end
   end

   // status towards the controller
   assign is_write = (kind_ff == REQ_KIND_WRITE);
   assign loopback = (src_ff == dst_ff);
   assign ttl_zero = (ttl_ff == '0);

   assign status.is_write   = is_write;
   assign status.early_drop = loopback || ttl_zero;
   assign status.last_entry = (cnt_ff == IDX_W'(STORE_DEPTH - 1));

   // table write, a slot outside the table is ignored
   assign slot_ok = ({1'b0, index_ff} < (INDEX_W + 1)'(STORE_DEPTH));
   assign wr_addr = index_ff[IDX_W-1:0];

   always_comb begin
      valid_tab_in = valid_tab_ff;
      if (cmd.write_en && slot_ok) valid_tab_in[wr_addr] = evalid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_tab_ff <= '0;
      end else begin
         valid_tab_ff <= valid_tab_in;
      end
   end

   // table words, cleared slots are zeroed
   always_ff @(posedge clock) begin
      if (cmd.write_en && slot_ok) begin
         dest_tab_ff[wr_addr] <= evalid_ff ? rdest_ff : '0;
         mask_tab_ff[wr_addr] <= evalid_ff ? rmask_ff : '0;
         hop_tab_ff[wr_addr]  <= evalid_ff ? rhop_ff  : '0;
      end
   end

   // entry under scan and its match test
   assign cur_dest = dest_tab_ff[cnt_ff];
   assign cur_mask = mask_tab_ff[cnt_ff];
   assign cur_hop  = hop_tab_ff[cnt_ff];
   assign hit      = valid_tab_ff[cnt_ff] && ((dst_ff & cur_mask) == cur_dest);
   // a later slot needs a strictly larger mask, so the lowest index wins ties
   assign take     = hit && (!found_ff || (cur_mask > best_mask_ff));

   // scan state update
   always_comb begin
      cnt_in       = cnt_ff;
      found_in     = found_ff;
      best_mask_in = best_mask_ff;
      best_hop_in  = best_hop_ff;
      if (cmd.scan_start) begin
         cnt_in       = '0;
         found_in     = 1'b0;
         best_mask_in = '0;
         best_hop_in  = '0;
      end else if (cmd.scan_step) begin
         cnt_in = cnt_ff + 1'b1;
         if (take) begin
            found_in     = 1'b1;
            best_mask_in = cur_mask;
            best_hop_in  = cur_hop;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_mask_ff <= best_mask_in;
      best_hop_ff  <= best_hop_in;
   end

   // verdict and result fields
   always_comb begin
      if (is_write) begin
         verdict = VERDICT_WRITE;
      end else if (loopback) begin
         verdict = VERDICT_LOOPBACK;
      end else if (ttl_zero) begin
         verdict = VERDICT_TTL_ZERO;
      end else if (found_ff) begin
         verdict = VERDICT_FORWARD;
      end else begin
         verdict = VERDICT_NO_ROUTE;
      end
   end

   assign hop_out = (verdict == VERDICT_FORWARD) ? best_hop_ff : '0;
   assign ttl_out = ((verdict == VERDICT_FORWARD) || (verdict == VERDICT_NO_ROUTE))
                    ? (ttl_ff - 1'b1) : '0;

   // result register
   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      if (cmd.load_rsp) begin
         rsp_data_in = {ttl_out, hop_out};
         rsp_user_in = verdict;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;

endmodule

// ----- rtl/ipv4_forward_longest_prefix.sv -----
// top level of the ipv4 longest prefix match forwarding block
//
// Request channel req_*: one beat is either a route write (tuser 0) that
// stores or clears one table slot, or a packet to forward (tuser 1) with
// source, destination and ttl. Every request beat yields exactly one beat
// on the response channel rsp_*: tuser carries the verdict, tdata the next
// hop and the decremented ttl.
// One request is worked on at a time; req_tready is high while the block
// waits for work. After the accept, a write or an early drop (loopback,
// ttl zero) passes through the exec and finish states into the output
// register; a lookup passes through the scan state between them, where the
// compare unit visits one stored slot a cycle, D = min(TABLE_DEPTH, 16)
// slots in all. The block takes the next request only after the finish
// state has handed the result to the output register.
// Slots above 15 can never be written and so are not stored.
// The result sits in an output register: a new request is accepted and
// worked on while an earlier result waits for rsp_tready; a finished
// result waits in the datapath until the output register frees up.
// Synchronous reset empties the route table and drops any result in flight.
module ipv4_forward_longest_prefix #(
   parameter int TABLE_DEPTH = ipv4_lpm_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // entry_index, entry_valid, route_dest, route_mask, route_hop,
   // pkt_src, pkt_dst, pkt_ttl, zero padding
   input  logic [ipv4_lpm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type
   input  logic [ipv4_lpm_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // next_hop, new_ttl
   output logic [ipv4_lpm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // verdict
   output logic [ipv4_lpm_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import ipv4_lpm_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing
   ipv4_lpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // table and compare
   ipv4_lpm_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// ----- rtl/ipv4_lpm_checker.sv -----
// port-level checks of the ipv4 longest prefix block and their bind
module ipv4_lpm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_tvalid,
   input logic                                 req_tready,
   input logic                                 rsp_tvalid,
   input logic                                 rsp_tready,
   input logic [ipv4_lpm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic [ipv4_lpm_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import ipv4_lpm_pkg::*;

   // no result beat straight after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("response valid right after reset");

   // one request at a time: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous one in work");

   // next hop is zero unless forwarded
   a_hop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != VERDICT_FORWARD)) |-> (rsp_tdata[ADDR_W-1:0] == '0))
      else $error("next hop set on a non-forward verdict");

   // ttl is zero on writes and early drops
   a_ttl_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tuser == VERDICT_WRITE) || (rsp_tuser == VERDICT_LOOPBACK) ||
                      (rsp_tuser == VERDICT_TTL_ZERO)))
      |-> (rsp_tdata[ADDR_W +: TTL_W] == '0))
      else $error("new ttl set on a verdict without decrement");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response beat changed");

endmodule

bind ipv4_forward_longest_prefix ipv4_lpm_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- verif/tb_ipv4_forward_longest_prefix.sv -----
// self-checking testbench for the ipv4 longest prefix match forwarding block
`timescale 1ns / 100ps

module tb_ipv4_forward_longest_prefix;
   import ipv4_lpm_pkg::*;

   localparam int IDLE_LIMIT   = 400;
   localparam int TAIL_CYCLES  = 40;
   localparam int RANDOM_ITEMS = 1725;
   localparam int CHUNK_ITEMS  = 250;
   localparam int TABLE_SLOTS  = (DEFAULT_TABLE_DEPTH < ENTRY_SLOTS) ?
                                 DEFAULT_TABLE_DEPTH : ENTRY_SLOTS;

   // one request beat, unpacked into its fields
   typedef struct {
      req_kind_type        kind;
      logic [INDEX_W-1:0]  index;
      logic                evalid;
      logic [ADDR_W-1:0]   rdest;
      logic [ADDR_W-1:0]   rmask;
      logic [ADDR_W-1:0]   rhop;
      logic [ADDR_W-1:0]   src;
      logic [ADDR_W-1:0]   dst;
      logic [TTL_W-1:0]    ttl;
   } req_item_type;

   // one expected response beat
   typedef struct {
      verdict_type         verdict;
      logic [ADDR_W-1:0]   hop;
      logic [TTL_W-1:0]    ttl;
   } verdict_expect_type;

   // shadow route table and the queue of verdicts still owed by the block
   class forward_verdict_book;
      logic [ADDR_W-1:0]  dest_tab [ENTRY_SLOTS];
      logic [ADDR_W-1:0]  mask_tab [ENTRY_SLOTS];
      logic [ADDR_W-1:0]  hop_tab  [ENTRY_SLOTS];
      bit                 valid_tab[ENTRY_SLOTS];
      verdict_expect_type owed_q[$];
      int                 errors;

      function new();
         for (int i = 0; i < ENTRY_SLOTS; i++) begin
            dest_tab[i]  = '0;
            mask_tab[i]  = '0;
            hop_tab[i]   = '0;
            valid_tab[i] = 1'b0;
         end
         errors = 0;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      // update the table or resolve the packet, and queue the verdict
      function void note_request(req_item_type r);
         verdict_expect_type e;
         logic               found;
         logic [ADDR_W-1:0]  best_mask;
         logic [ADDR_W-1:0]  best_hop;
         e.verdict = VERDICT_WRITE;
         e.hop     = '0;
         e.ttl     = '0;
         if (r.kind == REQ_KIND_WRITE) begin
            // slots beyond the table are ignored but still answered
            if (int'(r.index) < DEFAULT_TABLE_DEPTH) begin
               valid_tab[r.index] = r.evalid;
               dest_tab[r.index]  = r.evalid ? r.rdest : '0;
               mask_tab[r.index]  = r.evalid ? r.rmask : '0;
               hop_tab[r.index]   = r.evalid ? r.rhop  : '0;
            end
         end else if (r.src == r.dst) begin
            e.verdict = VERDICT_LOOPBACK;
         end else if (r.ttl == '0) begin
            e.verdict = VERDICT_TTL_ZERO;
         end else begin
            e.ttl     = r.ttl - 8'd1;
            found     = 1'b0;
            best_mask = '0;
            best_hop  = '0;
            // a later slot needs a strictly larger mask to win
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (valid_tab[i] && ((r.dst & mask_tab[i]) == dest_tab[i]) &&
                   (!found || mask_tab[i] > best_mask)) begin
                  found     = 1'b1;
                  best_mask = mask_tab[i];
                  best_hop  = hop_tab[i];
               end
            end
            if (found) begin
               e.verdict = VERDICT_FORWARD;
               e.hop     = best_hop;
            end else begin
               e.verdict = VERDICT_NO_ROUTE;
            end
         end
         owed_q.push_back(e);
      endfunction

      // compare one response beat against the oldest owed verdict
      function void check_response(logic [VERDICT_W-1:0] verdict,
                                   logic [ADDR_W-1:0] hop, logic [TTL_W-1:0] ttl);
         verdict_expect_type e;
         if (owed_q.size() == 0) begin
            $display("%0t: response with nothing owed: verdict %0d hop %h ttl %0d",
                     $time, verdict, hop, ttl);
            errors++;
            return;
         end
         e = owed_q.pop_front();
         if (verdict !== e.verdict) begin
            $display("%0t: verdict mismatch: expected %0d actual %0d",
                     $time, e.verdict, verdict);
            errors++;
         end
         if (hop !== e.hop) begin
            $display("%0t: next hop mismatch: expected %h actual %h", $time, e.hop, hop);
            errors++;
         end
         if (ttl !== e.ttl) begin
            $display("%0t: new ttl mismatch: expected %0d actual %0d", $time, e.ttl, ttl);
            errors++;
         end
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;

   forward_verdict_book book;
   int req_gap_max   = 3;
   int rsp_stall_max = 3;
   int idle_cycles   = 0;

   ipv4_forward_longest_prefix dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // all fields random, kind chosen by the caller
   function automatic req_item_type random_fields();
      req_item_type r;
      r.kind   = REQ_KIND_FORWARD;
      r.index  = INDEX_W'($urandom);
      r.evalid = 1'($urandom);
      r.rdest  = $urandom;
      r.rmask  = $urandom;
      r.rhop   = $urandom;
      r.src    = $urandom;
      r.dst    = $urandom;
      r.ttl    = TTL_W'($urandom);
      return r;
   endfunction

   function automatic req_item_type route_write(logic [INDEX_W-1:0] index, logic keep,
                                                logic [ADDR_W-1:0] d, logic [ADDR_W-1:0] m,
                                                logic [ADDR_W-1:0] h);
      req_item_type r;
      r        = random_fields();
      r.kind   = REQ_KIND_WRITE;
      r.index  = index;
      r.evalid = keep;
      r.rdest  = d;
      r.rmask  = m;
      r.rhop   = h;
      return r;
   endfunction

   function automatic req_item_type packet(logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] d,
                                           logic [TTL_W-1:0] t);
      req_item_type r;
      r      = random_fields();
      r.kind = REQ_KIND_FORWARD;
      r.src  = s;
      r.dst  = d;
      r.ttl  = t;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] prefix_mask(int len);
      if (len == 0) return '0;
      return 32'hFFFF_FFFF << (32 - len);
   endfunction

   // prefix lengths cluster on a few values so that equal masks are common
   function automatic int pick_prefix_len();
      case ($urandom_range(0, 3))
         0: begin
            return 8;
         end
         1: begin
            return 16;
         end
         2: begin
            return 24;
         end
         default: begin
            return $urandom_range(0, 32);
         end
      endcase
   endfunction

   // mostly well-formed routes and packets aimed at stored routes
   function automatic req_item_type random_item();
      req_item_type      r;
      int                k;
      logic [ADDR_W-1:0] m;
      r = random_fields();
      if ($urandom_range(0, 9) < 3) begin
         r.kind   = REQ_KIND_WRITE;
         r.evalid = ($urandom_range(0, 7) != 0);
         if ($urandom_range(0, 9) < 7) m = prefix_mask(pick_prefix_len());
         else m = $urandom;
         r.rmask = m;
         // a destination with bits outside its mask can never match
         if ($urandom_range(0, 9) < 8) r.rdest = r.rdest & m;
      end else begin
         r.kind = REQ_KIND_FORWARD;
         k      = $urandom_range(0, ENTRY_SLOTS - 1);
         if ($urandom_range(0, 9) < 6 && book.valid_tab[k])
            r.dst = book.dest_tab[k] | (r.dst & ~book.mask_tab[k]);
         case ($urandom_range(0, 19))
            0, 1: begin
               r.ttl = 8'd0;
            end
            2, 3: begin
               r.ttl = 8'd1;
            end
            4: begin
               r.ttl = 8'hFF;
            end
            default: begin
            end
         endcase
         if ($urandom_range(0, 19) == 0) r.src = r.dst;
      end
      return r;
   endfunction

   // offer one request beat after a random gap and wait for it to be taken
   task automatic send_request(req_item_type r);
      logic [REQ_TDATA_W-1:0] beat;
      int                     gap;
      beat = '0;
      beat[REQ_INDEX_LSB +: INDEX_W] = r.index;
      beat[REQ_EVALID_LSB]           = r.evalid;
      beat[REQ_RDEST_LSB +: ADDR_W]  = r.rdest;
      beat[REQ_RMASK_LSB +: ADDR_W]  = r.rmask;
      beat[REQ_RHOP_LSB +: ADDR_W]   = r.rhop;
      beat[REQ_SRC_LSB +: ADDR_W]    = r.src;
      beat[REQ_DST_LSB +: ADDR_W]    = r.dst;
      beat[REQ_TTL_LSB +: TTL_W]     = r.ttl;
      gap = $urandom_range(0, req_gap_max);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      req_tuser  <= r.kind;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      book.note_request(r);
   endtask

   // take one response beat after a random stall and check it
   task automatic collect_response();
      int stall;
      stall = $urandom_range(0, rsp_stall_max);
      repeat (stall) begin
         @(negedge clock);
         rsp_tready <= 1'b0;
      end
      @(negedge clock);
      rsp_tready <= 1'b1;
      do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      book.check_response(rsp_tuser, rsp_tdata[0 +: ADDR_W], rsp_tdata[ADDR_W +: TTL_W]);
   endtask

   initial begin
      int chunk;
      book = new();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      fork
         forever collect_response();
      join_none

      // empty table, then the drop checks and their priority
      send_request(packet(32'h0A00_0001, 32'hC0A8_0101, 8'd64));
      send_request(packet(32'h0000_0000, 32'h0000_0000, 8'd0));
      send_request(packet(32'h0102_0304, 32'h0506_0708, 8'd0));
      send_request(packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF));
      // default route in the lowest slot
      send_request(route_write(4'd0, 1'b1, 32'h0, 32'h0, 32'hA0A0_A0A0));
      send_request(packet(32'h0000_0000, 32'hFFFF_FFFF, 8'hFF));
      // host route in the highest slot, all ones
      send_request(route_write(4'hF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(packet(32'h0000_0000, 32'hFFFF_FFFF, 8'd1));
      // equal masks: the lower slot wins
      send_request(route_write(4'd3, 1'b1, 32'h0A00_0100, 32'hFFFF_FF00, 32'hB0B0_B0B0));
      send_request(route_write(4'd2, 1'b1, 32'h0A00_0100, 32'hFFFF_FF00, 32'hC0C0_C0C0));
      send_request(packet(32'h0A00_0001, 32'h0A00_0155, 8'd10));
      // shorter prefix only where the longer ones miss
      send_request(route_write(4'd5, 1'b1, 32'h0A00_0000, 32'hFFFF_0000, 32'hD0D0_D0D0));
      send_request(packet(32'h0A00_0001, 32'h0A00_FF01, 8'd2));
      // clearing a slot hands the match to the next one
      send_request(route_write(4'd2, 1'b0, $urandom, $urandom, $urandom));
      send_request(packet(32'h0A00_0001, 32'h0A00_0155, 8'd10));
      // without the default route an unmatched packet is dropped
      send_request(route_write(4'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(packet(32'h0A00_0001, 32'h0B00_0000, 8'd200));
      // destination with bits outside its mask never matches
      send_request(route_write(4'd7, 1'b1, 32'h0A00_01FF, 32'hFFFF_FF00, 32'hE0E0_E0E0));
      send_request(packet(32'h0A00_0001, 32'h0A00_01FF, 8'd33));
      send_request(packet(32'h0000_0001, 32'h0000_0000, 8'd0));
      send_request(packet(32'h0000_0001, 32'h0000_0000, 8'd1));

      // random part in chunks: full idling, none, receiver stalls only
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         chunk = n / CHUNK_ITEMS;
         case (chunk % 3)
            0: begin
               req_gap_max   = 3;
               rsp_stall_max = 3;
            end
            1: begin
               req_gap_max   = 0;
               rsp_stall_max = 0;
            end
            default: begin
               req_gap_max   = 0;
               rsp_stall_max = 3;
            end
         endcase
         send_request(random_item());
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then give stray beats a chance to show up
      while (book.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (book.errors == 0 && book.pending() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ipv4_lpm_pkg.sv
rtl/ipv4_lpm_ctrl.sv
rtl/ipv4_lpm_dpath.sv
rtl/ipv4_forward_longest_prefix.sv
rtl/ipv4_lpm_checker.sv
verif/tb_ipv4_forward_longest_prefix.sv
